[src/pjs_pkg.sv]
// Package with the shared constants and types of the priority job scheduler.
package pjs_pkg;

    // Number of job cells in the insertion chain.
    localparam int MAX_JOBS = 16;

    // Field widths.
    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TICK_W  = 20;
    localparam int CNT_W   = $clog2(MAX_JOBS + 1);

    // One job as it is held in a cell.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_job;

    // Cell contents with their valid flag.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_entry;

    // Chain-wide control broadcast to every cell.
    typedef struct packed {
        logic load;
        logic pop;
    } t_cell_ctl;

endpackage

[src/pjs_if.sv]
// Interfaces for the job input channel and the schedule output channel.
interface pjs_job_if;
    import pjs_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst_length;
    logic [PRIO_W-1:0]  job_priority;
    logic               batch_last;

    modport source (output valid, job_id, burst_length, job_priority, batch_last,
                    input ready);
    modport sink   (input valid, job_id, burst_length, job_priority, batch_last,
                    output ready);
endinterface

interface pjs_sched_if;
    import pjs_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    out_id;
    logic [BURST_W-1:0] out_burst;
    logic [PRIO_W-1:0]  out_priority;
    logic [TICK_W-1:0]  start_tick;
    logic [TICK_W-1:0]  end_tick;
    logic [TICK_W-1:0]  wait_ticks;
    logic [TICK_W-1:0]  turnaround_ticks;
    logic               schedule_last;

    modport source (output valid, out_id, out_burst, out_priority, start_tick, end_tick,
                    wait_ticks, turnaround_ticks, schedule_last,
                    input ready);
    modport sink   (input valid, out_id, out_burst, out_priority, start_tick, end_tick,
                    wait_ticks, turnaround_ticks, schedule_last,
                    output ready);
endinterface

[src/pjs_cell.sv]
// One cell of the sorted insertion chain: holds a job and trades it with its neighbors.
module pjs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pjs_pkg::t_cell_ctl i_ctl,
    input  pjs_pkg::t_job      i_new,
    input  logic               i_left_disp,
    input  pjs_pkg::t_entry    i_left,
    input  pjs_pkg::t_entry    i_right,
    output pjs_pkg::t_entry    o_entry,
    output logic               o_disp
);
    import pjs_pkg::*;

    logic r_valid;
    t_job r_job;
    logic n_valid;
    t_job n_job;

    // The new job goes in front of an empty cell or a strictly larger priority,
    // so equal priorities keep their load order.
    assign o_disp = !r_valid || (i_new.prio < r_job.prio);

    // Load shifts right from the insertion point; pop shifts everything left.
    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (i_ctl.pop) begin
            n_valid = i_right.valid;
            n_job   = i_right.job;
        end else if (i_ctl.load) begin
            if (i_left_disp) begin
                n_valid = i_left.valid;
                n_job   = i_left.job;
            end else if (o_disp) begin
                n_valid = 1'b1;
                n_job   = i_new;
            end
        end
    end

    // Valid flag is control state; the job payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_entry.valid = r_valid;
    assign o_entry.job   = r_job;

endmodule

[src/priority_job_scheduler.sv]
// Top level of the non-preemptive priority job scheduler.
//
//  Channel   Direction  Beat contents
//  i_job     in         job_id, burst_length, job_priority, batch_last
//  o_sched   out        out_id, out_burst, out_priority, start/end/wait/turnaround, last
//
// While loading, the input is always ready: each accepted job beat drops into its
// sorted place in a chain of MAX_JOBS cells in the cycle it is accepted, or is
// dropped if the chain is full. After the beat marked batch_last, the input is
// held off while the chain shifts the schedule out of its head cell, one job per
// cycle the output takes; once the head cell is empty, the block returns to
// loading.
// The output register lets the input accept beats while a result still waits.
// Reset (synchronous, active low) empties the chain and clears the tick clock.
module priority_job_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pjs_job_if.sink     i_job,
    pjs_sched_if.source o_sched
);
    import pjs_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                r_state;
    logic [CNT_W-1:0]    r_count;
    logic [TICK_W-1:0]   r_clock;
    logic                r_out_valid;
    t_job                r_out_job;
    logic [TICK_W-1:0]   r_out_start;
    logic [TICK_W-1:0]   r_out_end;
    logic                r_out_last;

    t_entry              w_entry [MAX_JOBS];
    logic                w_disp  [MAX_JOBS];
    t_cell_ctl           w_ctl;
    t_job                w_new;
    logic                w_full;
    logic                w_accept;
    logic                w_pop;
    logic [TICK_W:0]     w_sum;
    logic [TICK_W-1:0]   w_end;

    // Input handshake: jobs are taken only while loading.
    assign i_job.ready = (r_state == ST_LOAD);
    assign w_accept    = i_job.valid && i_job.ready;
    assign w_full      = (r_count == CNT_W'(MAX_JOBS));

    assign w_new.id    = i_job.job_id;
    assign w_new.burst = i_job.burst_length;
    assign w_new.prio  = i_job.job_priority;

    // While emitting, pop a valid head cell whenever the output register is free to take it.
    assign w_pop     = (r_state == ST_EMIT) && w_entry[0].valid
                       && (!r_out_valid || o_sched.ready);
    assign w_ctl.load = w_accept && !w_full;
    assign w_ctl.pop  = w_pop;

    // Chain of cells, head at index zero.
    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_disp;

        if (i == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_disp = 1'b0;
        end else begin : g_body
            assign w_left      = w_entry[i-1];
            assign w_left_disp = w_disp[i-1];
        end

        if (i == MAX_JOBS - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end

        pjs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_new       (w_new),
            .i_left_disp (w_left_disp),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_entry     (w_entry[i]),
            .o_disp      (w_disp[i])
        );
    end

    // Finish time of the head job, saturating at the top of the tick range.
    assign w_sum = (TICK_W+1)'(r_clock) + (TICK_W+1)'(w_entry[0].job.burst);
    assign w_end = w_sum[TICK_W] ? {TICK_W{1'b1}} : w_sum[TICK_W-1:0];

    // Sequencer, job count and running tick clock.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_clock <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (i_job.batch_last) begin
                            r_state <= ST_EMIT;
                            r_count <= '0;
                            r_clock <= '0;
                        end else if (!w_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    if (!w_entry[0].valid) begin
                        r_state <= ST_LOAD;
                    end else if (w_pop) begin
                        r_clock <= w_end;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_sched.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_job   <= w_entry[0].job;
            r_out_start <= r_clock;
            r_out_end   <= w_end;
            r_out_last  <= !w_entry[1].valid;
        end
    end

    assign o_sched.valid            = r_out_valid;
    assign o_sched.out_id           = r_out_job.id;
    assign o_sched.out_burst        = r_out_job.burst;
    assign o_sched.out_priority     = r_out_job.prio;
    assign o_sched.start_tick       = r_out_start;
    assign o_sched.end_tick         = r_out_end;
    assign o_sched.wait_ticks       = r_out_start;
    assign o_sched.turnaround_ticks = r_out_end;
    assign o_sched.schedule_last    = r_out_last;

    // The chain stays packed at the head and sorted by priority.
    for (genvar k = 1; k < MAX_JOBS; k++) begin : g_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_entry[k].valid |-> (w_entry[k-1].valid
                && (w_entry[k-1].job.prio <= w_entry[k].job.prio)))
            else $error("insertion chain lost its order");
    end

    // The job count never passes the number of cells.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS))
        else $error("job count beyond capacity");

    // A job never finishes before it starts.
    a_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_end >= r_out_start))
        else $error("end tick before start tick");

    // Popping the final job empties the chain.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_entry[1].valid) |=> !w_entry[0].valid)
        else $error("chain not empty after final job");

endmodule
